### rtl/cheb_pkg.sv
// Shared types, codes and constants for the Chebyshev series evaluator.
// Used by cheb_map, cheb_step, the top level and the checker; no dependencies.
package cheb_pkg;

  // Q-format word and field widths
  localparam int Q_W       = 32;
  localparam int IDX_W     = 4;
  localparam int TERM_W    = 5;
  localparam int CFG_IDX_W = 2;

  // quotient bits resolved per divider stage
  localparam int DIV_BITS_PER_STAGE = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TERMS = 2'd2;

  // register reset values: interval [-1.0, +1.0], 16 terms
  localparam logic signed [Q_W-1:0] RST_LOWER = -32'sd16777216;
  localparam logic signed [Q_W-1:0] RST_UPPER = 32'sd16777216;
  localparam logic [TERM_W-1:0]     RST_TERMS = 5'd16;

  // saturation limits
  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } opcode_e;

  // item fields that travel down the whole pipeline
  typedef struct packed {
    opcode_e                  op;
    logic [IDX_W-1:0]         idx;
    logic signed [Q_W-1:0]    coef;
  } item_t;

  // recurrence state: mapped point and the two previous terms
  typedef struct packed {
    logic signed [Q_W-1:0] y;
    logic signed [Q_W-1:0] d;
    logic signed [Q_W-1:0] dd;
  } rec_t;

  // clamp a sign-extended wide value to the Q word range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [2*Q_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = Q_MAX;
    end else if (v < -64'sd2147483648) begin
      r = Q_MIN;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/chebyshev_series_eval_unit.sv
// Top level of the Chebyshev series evaluator (Clenshaw recurrence, Q8.24).
// Depends on cheb_pkg, cheb_map and cheb_step.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_stall_o   opcode_i coef_index_i coef_value_i point_i
//   output    out        out_valid_o / out_stall_i value_o invalid_o
//   config    in         cfg_we_i (no wait)        cfg_index_i cfg_data_i
//
// One item enters per cycle while in_stall_o is low. The divider maps the point, then
// a multiply and an accumulate stage per term, the final term's multiply stage and the
// output register follow. Unstalled, each multiplier takes one item per cycle.
// Loads travel with evaluations and update each term's slot in order; no result for them.
// Reset clears configuration to [-1.0, +1.0] with 16 terms and all coefficients to zero.
// A result held under out_stall_i freezes the whole pipeline; bubbles are overwritten.
module chebyshev_series_eval_unit #(
  parameter int MAX_TERMS = 16,
  parameter int FRAC_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic [cheb_pkg::IDX_W-1:0]          coef_index_i,
  input  logic signed [cheb_pkg::Q_W-1:0]     coef_value_i,
  input  logic signed [cheb_pkg::Q_W-1:0]     point_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [cheb_pkg::Q_W-1:0]     value_o,
  output logic                                invalid_o,
  input  logic                                cfg_we_i,
  input  logic [cheb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cheb_pkg::Q_W-1:0]            cfg_data_i
);
  import cheb_pkg::*;

  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int P_W   = 2 * Q_W;
  localparam int R_W   = P_W - FRAC_BITS;
  localparam int ACC_W = R_W + 2;
  localparam logic signed [P_W-1:0] RND_BIAS = {{(P_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  // pipeline moves unless a finished result is held
  logic adv;
  logic out_valid_q;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign adv        = !in_stall_o;

  // configuration registers
  logic signed [Q_W-1:0] lower_q;
  logic signed [Q_W-1:0] upper_q;
  logic [TERM_W-1:0]     terms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= RST_LOWER;
      upper_q <= RST_UPPER;
      terms_q <= RST_TERMS;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LOWER: lower_q <= cfg_data_i;
        CFG_UPPER: upper_q <= cfg_data_i;
        CFG_TERMS: terms_q <= cfg_data_i[TERM_W-1:0];
        default:   ;
      endcase
    end
  end

  logic [CNT_W-1:0] m_eff;
  logic             bad_range;
  assign m_eff     = (32'(terms_q) > 32'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : CNT_W'(terms_q);
  assign bad_range = !(upper_q > lower_q);

  // incoming item
  item_t in_item;
  assign in_item = '{op: opcode_e'(opcode_i), idx: coef_index_i, coef: coef_value_i};

  // point mapping
  logic                  map_valid;
  item_t                 map_item;
  logic signed [Q_W-1:0] map_y;

  cheb_map #(
    .FRAC_BITS (FRAC_BITS)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .item_i  (in_item),
    .point_i (point_i),
    .lower_i (lower_q),
    .upper_i (upper_q),
    .valid_o (map_valid),
    .item_o  (map_item),
    .y_o     (map_y)
  );

  // recurrence chain, highest term first
  logic  ch_valid [MAX_TERMS];
  item_t ch_item  [MAX_TERMS];
  rec_t  ch_rec   [MAX_TERMS];

  assign ch_valid[0] = map_valid;
  assign ch_item[0]  = map_item;
  assign ch_rec[0]   = '{y: map_y, d: '0, dd: '0};

  for (genvar k = 0; k < MAX_TERMS - 1; k++) begin : g_step
    cheb_step #(
      .FRAC_BITS (FRAC_BITS),
      .TERM_IDX  (MAX_TERMS - 1 - k),
      .CNT_W     (CNT_W)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .m_eff_i (m_eff),
      .valid_i (ch_valid[k]),
      .item_i  (ch_item[k]),
      .rec_i   (ch_rec[k]),
      .valid_o (ch_valid[k+1]),
      .item_o  (ch_item[k+1]),
      .rec_o   (ch_rec[k+1])
    );
  end

  // final term, multiply stage: y * d
  logic                  fv_q;
  item_t                 fitem_q;
  rec_t                  frec_q;
  logic signed [P_W-1:0] fprod_d;
  logic signed [P_W-1:0] fprod_q;
  assign fprod_d = ch_rec[MAX_TERMS-1].y * ch_rec[MAX_TERMS-1].d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (adv) begin
      fv_q <= ch_valid[MAX_TERMS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fitem_q <= ch_item[MAX_TERMS-1];
      frec_q  <= ch_rec[MAX_TERMS-1];
      fprod_q <= fprod_d;
    end
  end

  // slot zero
  logic signed [Q_W-1:0] c0_q;
  logic                  c0_hit;
  assign c0_hit = fv_q && (fitem_q.op == OP_LOAD) && (fitem_q.idx == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q <= '0;
    end else if (adv && c0_hit) begin
      c0_q <= fitem_q.coef;
    end
  end

  // final sum: round(y*d) - dd + c0/2, saturated
  logic signed [Q_W:0]     half_sum;
  logic signed [Q_W:0]     half;
  logic signed [P_W-1:0]   fprod_rnd;
  logic signed [R_W-1:0]   frnd;
  logic signed [ACC_W-1:0] facc;
  logic signed [Q_W-1:0]   fsum;

  assign half_sum  = (Q_W+1)'(c0_q) + (Q_W+1)'(1);
  assign half      = half_sum >>> 1;
  assign fprod_rnd = fprod_q + RND_BIAS;
  assign frnd      = fprod_rnd[P_W-1:FRAC_BITS];
  assign facc      = ACC_W'(frnd) - ACC_W'(frec_q.dd) + ACC_W'(half);
  assign fsum      = sat_q(P_W'(facc));

  // output register
  logic signed [Q_W-1:0] value_q;
  logic                  invalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= fv_q && (fitem_q.op == OP_EVAL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      value_q   <= bad_range ? '0 : fsum;
      invalid_q <= bad_range;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign invalid_o   = invalid_q;

endmodule

### rtl/cheb_map.sv
// Point mapping y = (2x - a - b) / (b - a) as a pipelined restoring divider.
// Depends on cheb_pkg; stage count follows from DIV_BITS_PER_STAGE.
module cheb_map #(
  parameter int FRAC_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  cheb_pkg::item_t               item_i,
  input  logic signed [cheb_pkg::Q_W-1:0] point_i,
  input  logic signed [cheb_pkg::Q_W-1:0] lower_i,
  input  logic signed [cheb_pkg::Q_W-1:0] upper_i,
  output logic                          valid_o,
  output cheb_pkg::item_t               item_o,
  output logic signed [cheb_pkg::Q_W-1:0] y_o
);
  import cheb_pkg::*;

  localparam int DIV_STAGES = Q_W / DIV_BITS_PER_STAGE;
  localparam int NUM_W      = Q_W + 3;
  localparam int N_W        = Q_W + 2;
  localparam int SH         = Q_W - FRAC_BITS;
  localparam int CMP_W      = 2 * Q_W - FRAC_BITS;

  // divisor; the user must keep it static while items are in flight, not enforced here
  logic signed [Q_W:0] den_full;
  logic [Q_W-1:0]      den;
  assign den_full = (Q_W+1)'(upper_i) - (Q_W+1)'(lower_i);
  assign den      = den_full[Q_W-1:0];

  // stage A: signed numerator, split into sign and magnitude
  logic signed [NUM_W-1:0] num;
  logic signed [NUM_W-1:0] mag;
  assign num = (NUM_W'(point_i) <<< 1) - NUM_W'(lower_i) - NUM_W'(upper_i);
  assign mag = num[NUM_W-1] ? -num : num;

  logic           va_q;
  item_t          itema_q;
  logic           nega_q;
  logic [N_W-1:0] na_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      itema_q <= item_i;
      nega_q  <= num[NUM_W-1];
      na_q    <= mag[N_W-1:0];
    end
  end

  // divider chain; element 0 is stage B, each later element adds quotient bits
  logic           vd_q    [DIV_STAGES+1];
  item_t          itemd_q [DIV_STAGES+1];
  logic           negd_q  [DIV_STAGES+1];
  logic           ovfd_q  [DIV_STAGES+1];
  logic [Q_W-1:0] remd_q  [DIV_STAGES+1];
  logic [Q_W-1:0] nlowd_q [DIV_STAGES+1];
  logic [Q_W-1:0] quod_q  [DIV_STAGES+1];

  // stage B: range check on the integer part, initial remainder
  logic ovf_b;
  assign ovf_b = CMP_W'(na_q) >= (CMP_W'(den) << SH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q[0] <= 1'b0;
    end else if (adv_i) begin
      vd_q[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      itemd_q[0] <= itema_q;
      negd_q[0]  <= nega_q;
      ovfd_q[0]  <= ovf_b;
      remd_q[0]  <= Q_W'(na_q >> SH);
      nlowd_q[0] <= Q_W'(na_q << FRAC_BITS);
      quod_q[0]  <= '0;
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic [Q_W-1:0] rem_n;
    logic [Q_W-1:0] nlow_n;
    logic [Q_W-1:0] quo_n;

    // restoring steps: shift in the next dividend bit, subtract when it fits
    always_comb begin
      logic [Q_W:0] trial;
      rem_n  = remd_q[s];
      nlow_n = nlowd_q[s];
      quo_n  = quod_q[s];
      for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
        trial  = {rem_n, nlow_n[Q_W-1]};
        nlow_n = nlow_n << 1;
        if (trial >= {1'b0, den}) begin
          rem_n = Q_W'(trial - {1'b0, den});
          quo_n = {quo_n[Q_W-2:0], 1'b1};
        end else begin
          rem_n = trial[Q_W-1:0];
          quo_n = {quo_n[Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[s+1] <= 1'b0;
      end else if (adv_i) begin
        vd_q[s+1] <= vd_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        itemd_q[s+1] <= itemd_q[s];
        negd_q[s+1]  <= negd_q[s];
        ovfd_q[s+1]  <= ovfd_q[s];
        remd_q[s+1]  <= rem_n;
        nlowd_q[s+1] <= nlow_n;
        quod_q[s+1]  <= quo_n;
      end
    end
  end

  // stage Y: apply sign and saturate the quotient
  logic              neg_f;
  logic [Q_W-1:0]    quo_f;
  logic signed [Q_W-1:0] y_d;
  assign neg_f = negd_q[DIV_STAGES];
  assign quo_f = quod_q[DIV_STAGES];

  always_comb begin
    if (ovfd_q[DIV_STAGES]) begin
      y_d = neg_f ? Q_MIN : Q_MAX;
    end else if (neg_f) begin
      y_d = quo_f[Q_W-1] ? Q_MIN : -$signed(quo_f);
    end else begin
      y_d = quo_f[Q_W-1] ? Q_MAX : $signed(quo_f);
    end
  end

  logic                  vy_q;
  item_t                 itemy_q;
  logic signed [Q_W-1:0] y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vy_q <= 1'b0;
    end else if (adv_i) begin
      vy_q <= vd_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      itemy_q <= itemd_q[DIV_STAGES];
      y_q     <= y_d;
    end
  end

  assign valid_o = vy_q;
  assign item_o  = itemy_q;
  assign y_o     = y_q;

endmodule

### rtl/cheb_step.sv
// One Clenshaw recurrence step for a fixed term: multiply stage, then
// round, accumulate and saturate. Holds its own coefficient slot. Uses cheb_pkg.
module cheb_step #(
  parameter int FRAC_BITS = 24,
  parameter int TERM_IDX  = 1,
  parameter int CNT_W     = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [CNT_W-1:0] m_eff_i,
  input  logic             valid_i,
  input  cheb_pkg::item_t  item_i,
  input  cheb_pkg::rec_t   rec_i,
  output logic             valid_o,
  output cheb_pkg::item_t  item_o,
  output cheb_pkg::rec_t   rec_o
);
  import cheb_pkg::*;

  localparam int P_W   = 2 * Q_W;
  localparam int R_W   = P_W - FRAC_BITS;
  localparam int ACC_W = R_W + 3;
  localparam logic signed [P_W-1:0] RND_BIAS = {{(P_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  // multiply stage: y * d
  logic                  v1_q;
  item_t                 item1_q;
  rec_t                  rec1_q;
  logic signed [P_W-1:0] prod_d;
  logic signed [P_W-1:0] prod_q;

  assign prod_d = rec_i.y * rec_i.d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item1_q <= item_i;
      rec1_q  <= rec_i;
      prod_q  <= prod_d;
    end
  end

  // coefficient slot; a load passing this point updates it in item order
  logic signed [Q_W-1:0] coef_q;
  logic                  load_hit;
  logic                  active;
  assign load_hit = v1_q && (item1_q.op == OP_LOAD) &&
                    ({{(32-IDX_W){1'b0}}, item1_q.idx} == 32'(TERM_IDX));
  assign active   = (item1_q.op == OP_EVAL) && (32'(m_eff_i) > 32'(TERM_IDX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (adv_i && load_hit) begin
      coef_q <= item1_q.coef;
    end
  end

  // accumulate stage: d' = 2*round(y*d) - dd + c[j], saturated; inactive terms pass d and dd on
  logic signed [P_W-1:0]   prod_rnd;
  logic signed [R_W-1:0]   rnd;
  logic signed [ACC_W-1:0] acc;
  logic signed [Q_W-1:0]   d_new;
  rec_t                    rec_d;

  assign prod_rnd = prod_q + RND_BIAS;
  assign rnd      = prod_rnd[P_W-1:FRAC_BITS];
  assign acc      = (ACC_W'(rnd) <<< 1) - ACC_W'(rec1_q.dd) + ACC_W'(coef_q);
  assign d_new    = sat_q(P_W'(acc));

  always_comb begin
    rec_d = rec1_q;
    if (active) begin
      rec_d.d  = d_new;
      rec_d.dd = rec1_q.d;
    end
  end

  logic  v2_q;
  item_t item2_q;
  rec_t  rec2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item2_q <= item1_q;
      rec2_q  <= rec_d;
    end
  end

  assign valid_o = v2_q;
  assign item_o  = item2_q;
  assign rec_o   = rec2_q;

endmodule

### rtl/cheb_checker.sv
// Port-level checks for chebyshev_series_eval_unit, attached by bind.
// Depends on cheb_pkg for port widths.
module cheb_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            opcode_i,
  input logic [cheb_pkg::IDX_W-1:0]      coef_index_i,
  input logic signed [cheb_pkg::Q_W-1:0] coef_value_i,
  input logic signed [cheb_pkg::Q_W-1:0] point_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic signed [cheb_pkg::Q_W-1:0] value_o,
  input logic                            invalid_o
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) && $stable(invalid_o))
    else $error("held result changed");

  // a stalled input item keeps its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(opcode_i) &&
      $stable(coef_index_i) && $stable(coef_value_i) && $stable(point_i))
    else $error("stalled input item changed");

  // an empty interval always reports zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o |-> value_o == '0)
    else $error("invalid result with nonzero value");

  // input back-pressure only comes from a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without blocked output");

endmodule

bind chebyshev_series_eval_unit cheb_checker u_checker (.*);

### dv/chebyshev_series_eval_unit_test.sv
// Testbench for chebyshev_series_eval_unit: coefficient loads and Clenshaw evaluations
// under random idling, checked item by item against an in-bench fixed-point predictor.
// Depends on cheb_pkg and the RTL of chebyshev_series_eval_unit.
module chebyshev_series_eval_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cheb_pkg::*;

  localparam int NTERMS     = 16;
  localparam int FRAC       = 24;
  // pipeline depth at 16 terms plus margin
  localparam int DRAIN      = 64;
  localparam int QUIET_MAX  = 4000;
  localparam int HOLD_LEN   = 300;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic signed [Q_W-1:0] ONE = 32'sh0100_0000;

  typedef struct {
    opcode_e               op;
    logic [IDX_W-1:0]      idx;
    logic signed [Q_W-1:0] coef;
    logic signed [Q_W-1:0] x;
  } series_item_t;

  typedef struct {
    logic signed [Q_W-1:0] value;
    logic                  invalid;
  } series_out_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  // block inputs, known from time zero
  logic                  in_valid = 1'b0;
  opcode_e               opcode = OP_LOAD;
  logic [IDX_W-1:0]      coef_idx = '0;
  logic signed [Q_W-1:0] coef_val = '0;
  logic signed [Q_W-1:0] point = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [Q_W-1:0]        cfg_data = '0;

  logic                  in_stall;
  logic                  out_valid;
  logic signed [Q_W-1:0] value;
  logic                  invalid;

  chebyshev_series_eval_unit #(
    .MAX_TERMS(NTERMS),
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .opcode_i    (opcode),
    .coef_index_i(coef_idx),
    .coef_value_i(coef_val),
    .point_i     (point),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .value_o     (value),
    .invalid_o   (invalid),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // predictor state: register copies and coefficient table
  logic signed [Q_W-1:0]    lo_q = RST_LOWER;
  logic signed [Q_W-1:0]    hi_q = RST_UPPER;
  logic [TERM_W-1:0]        terms_q = RST_TERMS;
  logic signed [Q_W-1:0]    coef_copy [NTERMS];

  series_item_t pending_items [$];
  series_out_t  expected_values [$];
  int issued_cnt = 0;
  int taken_cnt = 0;
  int fail_cnt = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_armed = 1'b0;

  initial begin
    foreach (coef_copy[i]) coef_copy[i] = '0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_cnt++;
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [Q_W-1:0] clamp_q(input longint v);
    if (v > 64'sd2147483647) return Q_MAX;
    if (v < -64'sd2147483648) return Q_MIN;
    return v[Q_W-1:0];
  endfunction

  // nearest, ties toward +inf
  function automatic longint round_q(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint mul_q(input logic signed [Q_W-1:0] a,
                                   input logic signed [Q_W-1:0] b);
    return round_q(longint'(a) * longint'(b), FRAC);
  endfunction

  // y = (2x - a - b) / (b - a), truncated toward zero, saturated
  function automatic logic signed [Q_W-1:0] map_to_unit(input logic signed [Q_W-1:0] x);
    longint                num;
    longint unsigned       n;
    longint unsigned       den;
    longint unsigned       q;
    logic signed [Q_W-1:0] r;
    num = 2 * longint'(x) - longint'(lo_q) - longint'(hi_q);
    den = $unsigned(longint'(hi_q) - longint'(lo_q));
    n = (num < 0) ? $unsigned(-num) : $unsigned(num);
    if (n / den >= 64'd256) q = 64'h1_0000_0000;
    else q = (n << FRAC) / den;
    if (num < 0) begin
      if (q >= 64'h8000_0000) return Q_MIN;
      r = q[Q_W-1:0];
      return -r;
    end
    if (q > 64'h7FFF_FFFF) return Q_MAX;
    return q[Q_W-1:0];
  endfunction

  function automatic series_out_t eval_series(input logic signed [Q_W-1:0] x);
    series_out_t           res;
    logic signed [Q_W-1:0] y;
    logic signed [Q_W-1:0] d;
    logic signed [Q_W-1:0] dd;
    logic signed [Q_W-1:0] keep;
    int                    m;
    if (hi_q <= lo_q) begin
      res.value = '0;
      res.invalid = 1'b1;
      return res;
    end
    y = map_to_unit(x);
    m = (terms_q > NTERMS) ? NTERMS : int'(terms_q);
    d = '0;
    dd = '0;
    // backward recurrence over c[m-1] .. c[1]
    for (int j = m - 1; j > 0; j--) begin
      keep = d;
      d = clamp_q(2 * mul_q(y, d) - longint'(dd) + longint'(coef_copy[j]));
      dd = keep;
    end
    res.value = clamp_q(mul_q(y, d) - longint'(dd) + round_q(longint'(coef_copy[0]), 1));
    res.invalid = 1'b0;
    return res;
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk or negedge rst_n) begin : item_driver
    series_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        opcode   <= it.op;
        coef_idx <= it.idx;
        coef_val <= it.coef;
        point    <= it.x;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: random, or one long hold-off when armed
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- monitors

  // accepted input item: update table or predict the series value
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      if (opcode == OP_LOAD) coef_copy[coef_idx] = coef_val;
      else expected_values.push_back(eval_series(point));
      taken_cnt++;
    end
  end

  // accepted result item: compare with the oldest prediction
  always @(posedge clk) begin : result_check
    series_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_values.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %h invalid %b", value, invalid));
      end else begin
        want = expected_values.pop_front();
        if (value !== want.value)
          report_mismatch($sformatf("value %h, want %h", value, want.value));
        if (invalid !== want.invalid)
          report_mismatch($sformatf("invalid %b, want %b", invalid, want.invalid));
      end
    end
  end

  // watchdog on cycles with no handshake at all
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_MAX) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LOWER: lo_q = data;
      CFG_UPPER: hi_q = data;
      CFG_TERMS: terms_q = data[TERM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic push_item(input opcode_e op, input logic [IDX_W-1:0] idx,
                           input logic signed [Q_W-1:0] c, input logic signed [Q_W-1:0] x);
    series_item_t it;
    it.op = op;
    it.idx = idx;
    it.coef = c;
    it.x = x;
    pending_items.push_back(it);
    issued_cnt++;
  endtask

  // random loads and evaluations; most points inside the current interval
  task automatic queue_random(input int n);
    logic signed [Q_W-1:0] c;
    logic signed [Q_W-1:0] x;
    longint                span;
    longint                pos;
    longint unsigned       r;
    opcode_e               op;
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 99) < 35) ? OP_LOAD : OP_EVAL;
      case ($urandom_range(0, 9))
        0: c = $urandom;
        1: c = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
        default: c = $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          if (hi_q > lo_q) begin
            span = longint'(hi_q) - longint'(lo_q) + 1;
            r = {$urandom, $urandom};
            pos = longint'(lo_q) + longint'(r % $unsigned(span));
            x = pos[Q_W-1:0];
          end else begin
            x = $urandom;
          end
        end
        6: x = $urandom_range(0, 1) ? lo_q : hi_q;
        7: x = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
        default: x = $urandom;
      endcase
      push_item(op, IDX_W'($urandom), c, x);
    end
  endtask

  // wait until every item is taken and every result checked
  task automatic drain();
    while (taken_cnt != issued_cnt) @(posedge clk);
    while (expected_values.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin
    logic signed [Q_W-1:0] a;
    logic signed [Q_W-1:0] b;
    send_idle_pct = 6;
    recv_idle_pct = 59;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, extreme coefficients, endpoints, c0 halving ties
    push_item(OP_EVAL, 4'd0, '0, '0);
    push_item(OP_LOAD, 4'd0, Q_MAX, Q_MIN);
    push_item(OP_LOAD, 4'd15, Q_MIN, Q_MAX);
    push_item(OP_LOAD, 4'd1, ONE, '0);
    push_item(OP_LOAD, 4'd2, -32'sh0080_0000, '0);
    push_item(OP_EVAL, 4'hF, 32'hFFFF_FFFF, Q_MIN);
    push_item(OP_EVAL, 4'hF, 32'hFFFF_FFFF, Q_MAX);
    push_item(OP_EVAL, 4'd0, '0, -ONE);
    push_item(OP_EVAL, 4'd0, '0, ONE);
    push_item(OP_EVAL, 4'd0, '0, '0);
    push_item(OP_EVAL, 4'd0, '0, 32'sh0080_0000);
    push_item(OP_LOAD, 4'd0, -32'sd3, '0);
    push_item(OP_LOAD, 4'd15, '0, '0);
    push_item(OP_EVAL, 4'd0, '0, 32'sh0040_0000);
    push_item(OP_LOAD, 4'd0, 32'sd3, '0);
    push_item(OP_EVAL, 4'd0, '0, -32'sh0040_0000);
    push_item(OP_LOAD, 4'd0, Q_MIN, '0);
    push_item(OP_LOAD, 4'd7, Q_MAX, '0);
    push_item(OP_EVAL, 4'd0, '0, Q_MAX);
    push_item(OP_EVAL, 4'd0, '0, 32'sh00C0_0000);
    queue_random(10);
    drain();

    // eight terms; random upper data bits to show only the low five count
    write_reg(CFG_TERMS, ($urandom & ~32'h1F) | 32'd8);
    queue_random(40);
    drain();

    // interval [0, 4.0], zero terms
    write_reg(CFG_LOWER, '0);
    write_reg(CFG_UPPER, 32'h0400_0000);
    write_reg(CFG_TERMS, 32'd0);
    queue_random(40);
    drain();

    // interval [-3.5, 2.25], single term
    write_reg(CFG_LOWER, -32'sh0380_0000);
    write_reg(CFG_UPPER, 32'sh0240_0000);
    write_reg(CFG_TERMS, 32'd1);
    queue_random(40);
    drain();

    // sender idles more than receiver from here
    send_idle_pct = 59;
    recv_idle_pct = 6;

    // widest interval, term count above the table size
    write_reg(CFG_LOWER, Q_MIN);
    write_reg(CFG_UPPER, Q_MAX);
    write_reg(CFG_TERMS, 32'd31);
    queue_random(40);
    drain();

    // empty interval: every evaluation flagged
    write_reg(CFG_LOWER, ONE);
    write_reg(CFG_UPPER, ONE);
    write_reg(CFG_TERMS, 32'd16);
    queue_random(40);
    drain();

    // reversed interval
    write_reg(CFG_LOWER, Q_MAX);
    write_reg(CFG_UPPER, Q_MIN);
    write_reg(CFG_TERMS, 32'd17);
    queue_random(40);
    drain();

    // no idling from here
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // one-LSB interval saturates the mapped point outside it; spare index must be ignored
    write_reg(CFG_LOWER, '0);
    write_reg(CFG_UPPER, 32'd1);
    write_reg(CFG_TERMS, 32'd2);
    write_reg(CFG_SPARE, $urandom);
    queue_random(40);
    drain();

    // random interval, ordered most of the time
    a = $urandom;
    b = $urandom;
    if (a > b && $urandom_range(0, 3) != 0) begin
      write_reg(CFG_LOWER, b);
      write_reg(CFG_UPPER, a);
    end else begin
      write_reg(CFG_LOWER, a);
      write_reg(CFG_UPPER, b);
    end
    write_reg(CFG_TERMS, $urandom_range(0, 31));
    queue_random(40);
    drain();

    // back to [-1, 1] at full length with a long receiver hold-off
    write_reg(CFG_LOWER, -ONE);
    write_reg(CFG_UPPER, ONE);
    write_reg(CFG_TERMS, 32'd16);
    @(negedge clk);
    hold_armed = 1'b1;
    queue_random(100);
    drain();

    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/cheb_pkg.sv
rtl/cheb_map.sv
rtl/cheb_step.sv
rtl/chebyshev_series_eval_unit.sv
rtl/cheb_checker.sv
dv/chebyshev_series_eval_unit_test.sv
